>>> rtl/slru_pkg.sv
// Shared types and constants of the segmented LRU replacement unit.
// Used by slru_lists and segmented_lru_replacement_unit; depends on nothing.
`default_nettype none
package slru_pkg;

    localparam int CAPACITY = 32;
    localparam int ID_BITS  = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LIM_W    = 5;
    localparam int CFG_AW   = 1;

    // Request codes carried on the input tuser.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_HIT    = 2'd1;
    localparam logic [1:0] REQ_ERASE  = 2'd2;

    // Segment codes reported in each result.
    localparam logic [1:0] SEG_NONE = 2'd0;
    localparam logic [1:0] SEG_PROB = 2'd1;
    localparam logic [1:0] SEG_PROT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_PROB_LIMIT = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_PROT_LIMIT = 1'b1;

    // One access to the list memories: one read and one write per cycle.
    typedef struct packed {
        logic               rd_en;
        logic               rd_prot;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic               wr_prot;
        logic [IDX_W-1:0]   wr_addr;
        logic [ID_BITS-1:0] wr_data;
    } t_mem_req;

endpackage
`default_nettype wire

>>> rtl/slru_lists.sv
// Two ordered id lists (probation and protected), each a synchronous memory.
// Depends on slru_pkg for widths and the access request struct.
`default_nettype none
module slru_lists (
    input  wire logic                      i_clk,
    input  wire slru_pkg::t_mem_req        i_req,
    output logic [slru_pkg::ID_BITS-1:0]   o_rd_data
);

    logic [slru_pkg::ID_BITS-1:0] prob_mem [slru_pkg::CAPACITY];
    logic [slru_pkg::ID_BITS-1:0] prot_mem [slru_pkg::CAPACITY];
    logic [slru_pkg::ID_BITS-1:0] r_rd_data;

    // Write port, steered to one of the two lists.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && !i_req.wr_prot) begin
            prob_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.wr_en && i_req.wr_prot) begin
            prot_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read; the data holds while no new read is issued.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= i_req.rd_prot ? prot_mem[i_req.rd_addr]
                                       : prob_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> rtl/segmented_lru_replacement_unit.sv
// Segmented LRU replacement unit: sequencer and result register; uses slru_pkg, slru_lists.
// Order of work: an unknown request code goes straight to the result; otherwise the lists are
// searched, the unit acts, closes gaps and appends, works out evictions and demotions, evicts,
// demotes and loads the result; the shifts after evictions follow the last result.
// Throughput: one transaction in work at a time, input ready only when idle; an unread result
// stalls the sequencer. Reset clears both segments and loads the limits 16 and 15.
`default_nettype none
module segmented_lru_replacement_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] entry_id
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] req_type
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] evicted_id, [9:8] hit_segment, [10] overflow,
    // [16:11] probation_count, [22:17] protected_count, [23] zero
    output logic [23:0]      o_m_axis_tdata,
    output logic             o_m_axis_tuser,   // [0] evict_valid
    output logic             o_m_axis_tlast,
    input  wire logic                            i_cfg_we,
    input  wire logic [slru_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [slru_pkg::LIM_W-1:0]      i_cfg_wdata
);

    localparam int CW = slru_pkg::CNT_W;
    localparam int IW = slru_pkg::IDX_W;
    localparam int DW = slru_pkg::ID_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_FIND_CHK, S_ACT, S_SH_RD, S_SH_WR, S_HIT_APP,
        S_PASS, S_EV_RD, S_EV_OUT, S_DM_START, S_CP_RD, S_CP_WR, S_POST, S_FINAL
    } t_state;

    t_state                  r_state, r_after;
    logic [1:0]              r_req;
    logic [DW-1:0]           r_id;
    logic [CW-1:0]           r_psize, r_qsize, r_k, r_pos, r_end, r_d;
    logic [CW-1:0]           r_evn, r_dmn, r_fp, r_fq;
    logic                    r_list, r_sh_list, r_found, r_ovf;
    logic [slru_pkg::LIM_W-1:0] r_plim, r_qlim;

    logic                    r_o_valid, r_o_evict, r_o_last, r_o_ovf;
    logic [DW-1:0]           r_o_id;
    logic [1:0]              r_o_seg;
    logic [CW-1:0]           r_o_pc, r_o_qc;

    slru_pkg::t_mem_req      mem_req;
    logic [DW-1:0]           rd_data;
    logic                    out_free, out_load;
    logic [CW-1:0]           list_size, evn, dmn;
    logic [CW:0]             used;
    logic [1:0]              seg;

    slru_lists u_lists (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign out_free  = !r_o_valid || i_m_axis_tready;
    assign out_load  = out_free && (r_state == S_EV_OUT || r_state == S_FINAL);
    assign list_size = r_list ? r_qsize : r_psize;
    assign used      = {1'b0, r_psize} + {1'b0, r_qsize};
    assign evn = (r_psize > {1'b0, r_plim}) ? (r_psize - {1'b0, r_plim}) : '0;
    assign dmn = (r_qsize > {1'b0, r_qlim}) ? (r_qsize - {1'b0, r_qlim}) : '0;
    assign seg = (r_found && r_req != slru_pkg::REQ_INSERT)
               ? (r_list ? slru_pkg::SEG_PROT : slru_pkg::SEG_PROB) : slru_pkg::SEG_NONE;

    // Memory accesses issued by the current step.
    always_comb begin
        mem_req = '0;
        unique case (r_state)
            S_FIND: begin
                mem_req.rd_en   = (r_k < list_size);
                mem_req.rd_prot = r_list;
                mem_req.rd_addr = r_k[IW-1:0];
            end
            S_ACT: begin
                mem_req.wr_en   = (r_req == slru_pkg::REQ_INSERT) && !r_found
                                  && (used < (CW+1)'(slru_pkg::CAPACITY));
                mem_req.wr_prot = 1'b0;
                mem_req.wr_addr = r_psize[IW-1:0];
                mem_req.wr_data = r_id;
            end
            S_SH_RD: begin
                mem_req.rd_en   = (r_k < r_end);
                mem_req.rd_prot = r_sh_list;
                mem_req.rd_addr = IW'(r_k + r_d);
            end
            S_SH_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_prot = r_sh_list;
                mem_req.wr_addr = r_k[IW-1:0];
                mem_req.wr_data = rd_data;
            end
            S_HIT_APP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_prot = 1'b1;
                mem_req.wr_addr = r_qsize[IW-1:0];
                mem_req.wr_data = r_id;
            end
            S_EV_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_prot = 1'b0;
                mem_req.rd_addr = r_k[IW-1:0];
            end
            S_CP_RD: begin
                mem_req.rd_en   = (r_k < r_dmn);
                mem_req.rd_prot = 1'b1;
                mem_req.rd_addr = r_k[IW-1:0];
            end
            S_CP_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_prot = 1'b0;
                mem_req.wr_addr = IW'(r_psize + r_k);
                mem_req.wr_data = rd_data;
            end
            default: mem_req = '0;
        endcase
    end

    // Sequencer, sizes, limits and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after   <= S_IDLE;
            r_psize   <= '0;
            r_qsize   <= '0;
            r_plim    <= slru_pkg::LIM_W'(16);
            r_qlim    <= slru_pkg::LIM_W'(15);
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    slru_pkg::CFG_PROB_LIMIT: r_plim <= i_cfg_wdata;
                    slru_pkg::CFG_PROT_LIMIT: r_qlim <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_o_valid && i_m_axis_tready && !out_load) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_req   <= i_s_axis_tuser;
                        r_id    <= i_s_axis_tdata;
                        r_k     <= '0;
                        r_list  <= 1'b0;
                        r_found <= 1'b0;
                        r_ovf   <= 1'b0;
                        r_evn   <= '0;
                        if (i_s_axis_tuser == slru_pkg::REQ_INSERT
                            || i_s_axis_tuser == slru_pkg::REQ_HIT
                            || i_s_axis_tuser == slru_pkg::REQ_ERASE) begin
                            r_state <= S_FIND;
                        end else begin
                            r_state <= S_FINAL;
                        end
                    end
                end
                // Linear search: probation first, then protected.
                S_FIND: begin
                    if (r_k < list_size) begin
                        r_state <= S_FIND_CHK;
                    end else if (!r_list) begin
                        r_list <= 1'b1;
                        r_k    <= '0;
                    end else begin
                        r_state <= S_ACT;
                    end
                end
                S_FIND_CHK: begin
                    if (rd_data == r_id) begin
                        r_found <= 1'b1;
                        r_pos   <= r_k;
                        r_state <= S_ACT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_FIND;
                    end
                end
                S_ACT: begin
                    if (r_req == slru_pkg::REQ_INSERT) begin
                        if (r_found) begin
                            r_state <= S_PASS;
                        end else if (used >= (CW+1)'(slru_pkg::CAPACITY)) begin
                            r_ovf   <= 1'b1;
                            r_state <= S_FINAL;
                        end else begin
                            r_psize <= r_psize + 1'b1;
                            r_state <= S_PASS;
                        end
                    end else if (r_found) begin
                        // Remove the found id by closing the gap in its list.
                        r_sh_list <= r_list;
                        r_k       <= r_pos;
                        r_d       <= CW'(1);
                        r_end     <= list_size - 1'b1;
                        if (r_list) r_qsize <= r_qsize - 1'b1;
                        else        r_psize <= r_psize - 1'b1;
                        r_after   <= (r_req == slru_pkg::REQ_HIT) ? S_HIT_APP : S_FINAL;
                        r_state   <= S_SH_RD;
                    end else begin
                        r_state <= (r_req == slru_pkg::REQ_HIT) ? S_PASS : S_FINAL;
                    end
                end
                // Move entries k+d down to k, one entry at a time: read it, then write it.
                S_SH_RD: begin
                    r_state <= (r_k < r_end) ? S_SH_WR : r_after;
                end
                S_SH_WR: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= S_SH_RD;
                end
                S_HIT_APP: begin
                    r_qsize <= r_qsize + 1'b1;
                    r_state <= S_PASS;
                end
                // Work out eviction and demotion counts and the final sizes.
                S_PASS: begin
                    r_evn   <= evn;
                    r_dmn   <= dmn;
                    r_fp    <= r_psize - evn + dmn;
                    r_fq    <= r_qsize - dmn;
                    r_k     <= '0;
                    r_state <= (evn != '0) ? S_EV_RD : S_DM_START;
                end
                S_EV_RD: begin
                    r_state <= S_EV_OUT;
                end
                S_EV_OUT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_evict <= 1'b1;
                        r_o_id    <= rd_data;
                        r_o_seg   <= seg;
                        r_o_ovf   <= 1'b0;
                        r_o_pc    <= r_fp;
                        r_o_qc    <= r_fq;
                        r_o_last  <= (r_k + 1'b1 == r_evn);
                        if (r_k + 1'b1 == r_evn) begin
                            r_sh_list <= 1'b0;
                            r_k       <= '0;
                            r_d       <= r_evn;
                            r_end     <= r_psize - r_evn;
                            r_psize   <= r_psize - r_evn;
                            r_after   <= S_DM_START;
                            r_state   <= S_SH_RD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_EV_RD;
                        end
                    end
                end
                S_DM_START: begin
                    r_k     <= '0;
                    r_state <= (r_dmn != '0) ? S_CP_RD : S_POST;
                end
                // Copy the protected head onto the probation tail.
                S_CP_RD: begin
                    if (r_k < r_dmn) begin
                        r_state <= S_CP_WR;
                    end else begin
                        r_psize   <= r_psize + r_dmn;
                        r_sh_list <= 1'b1;
                        r_k       <= '0;
                        r_d       <= r_dmn;
                        r_end     <= r_qsize - r_dmn;
                        r_qsize   <= r_qsize - r_dmn;
                        r_after   <= S_POST;
                        r_state   <= S_SH_RD;
                    end
                end
                S_CP_WR: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= S_CP_RD;
                end
                S_POST: begin
                    r_state <= (r_evn == '0) ? S_FINAL : S_IDLE;
                end
                // Single result of a transaction that evicted nothing.
                S_FINAL: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_evict <= 1'b0;
                        r_o_id    <= '0;
                        r_o_seg   <= seg;
                        r_o_ovf   <= r_ovf;
                        r_o_pc    <= r_psize;
                        r_o_qc    <= r_qsize;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tuser  = r_o_evict;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {1'b0, r_o_qc, r_o_pc, r_o_ovf, r_o_seg, r_o_id};

    // The two segments never hold more ids than the store has room for.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= (CW+1)'(slru_pkg::CAPACITY))
        else $error("segment sizes exceed capacity");

    // A result without an eviction is always the closing one of its transaction.
    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_evict) |-> r_o_last)
        else $error("non-eviction result not marked last");

    // Once an input transaction is taken the block is busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted twice in a row");

endmodule
`default_nettype wire
